@@ sv/hsfe_pkg.sv @@
// Shared constants, types, coefficient tables and arithmetic helpers for the shape evaluator.
package hsfe_pkg;

    // Field widths of the channel words
    localparam int ORDER_W  = 4;
    localparam int IDX_W    = 4;
    localparam int DIR_W    = 2;
    localparam int XI_W     = 18;
    localparam int OUT_W    = 24;
    localparam int STATUS_W = 2;

    // Fixed-point layout
    localparam int FRAC_BITS    = 16;
    localparam int ACC_FRAC     = 28;
    localparam int ACC_INT_BITS = 17;
    localparam int ACC_LIM_LOG  = ACC_FRAC + ACC_INT_BITS;
    localparam int ACC_W        = ACC_LIM_LOG + 2;
    localparam int PROD_W       = ACC_W + XI_W;
    localparam int OUT_SH       = ACC_FRAC - FRAC_BITS;

    // Function set and pipeline shape
    localparam int N_FUNCS      = 9;
    localparam int N_TERMS      = 9;
    localparam int HORNER_STEPS = N_TERMS - 1;
    localparam int N_PIPE       = 2 * HORNER_STEPS + 1;
    localparam int ORDER_MIN    = 1;
    localparam int ORDER_MAX    = 7;

    localparam logic signed [PROD_W-1:0] STEP_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] OUT_HALF  = PROD_W'(1) <<< (OUT_SH - 1);
    localparam logic signed [PROD_W-1:0] ACC_MAX   = PROD_W'(1) <<< ACC_LIM_LOG;
    localparam logic signed [PROD_W-1:0] ACC_MIN   = -ACC_MAX;
    localparam logic signed [PROD_W-1:0] OUT_MAX   = (PROD_W'(1) <<< (OUT_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] OUT_MIN   = -(PROD_W'(1) <<< (OUT_W - 1));

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ORDER = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_BAD_DIR   = 2'd3
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        status_t                  status;
        logic signed [XI_W-1:0]   x;
        logic signed [PROD_W-1:0] val;
        logic signed [PROD_W-1:0] slp;
    } pipe_t;

    typedef logic [N_FUNCS-1:0][N_TERMS-1:0][ACC_W-1:0] coef_tab_t;

    // Table select: 0 for the function, 1 for its derivative
    localparam int POLY_RAD [2][N_FUNCS] = '{
        '{1, 1, 6, 10, 14, 2, 22, 26, 30},
        '{1, 1, 6, 10, 14, 2, 22, 26, 30}
    };

    localparam int POLY_SH [2][N_FUNCS] = '{
        '{1, 1, 2, 2, 4, 4, 5, 5, 8},
        '{1, 1, 1, 2, 2, 4, 4, 5, 5}
    };

    localparam int POLY_C [2][N_FUNCS][N_TERMS] = '{
        '{
            '{ 1, -1,    0,   0,    0,   0,    0,   0,   0},
            '{ 1,  1,    0,   0,    0,   0,    0,   0,   0},
            '{-1,  0,    1,   0,    0,   0,    0,   0,   0},
            '{ 0, -1,    0,   1,    0,   0,    0,   0,   0},
            '{ 1,  0,   -6,   0,    5,   0,    0,   0,   0},
            '{ 0,  9,    0, -30,    0,  21,    0,   0,   0},
            '{-1,  0,   15,   0,  -35,   0,   21,   0,   0},
            '{ 0, -5,    0,  35,    0, -63,    0,  33,   0},
            '{ 5,  0, -140,   0,  630,   0, -924,   0, 429}
        },
        '{
            '{-1,   0,    0,    0,    0,    0,  0,   0, 0},
            '{ 1,   0,    0,    0,    0,    0,  0,   0, 0},
            '{ 0,   1,    0,    0,    0,    0,  0,   0, 0},
            '{-1,   0,    3,    0,    0,    0,  0,   0, 0},
            '{ 0,  -3,    0,    5,    0,    0,  0,   0, 0},
            '{ 9,   0,  -90,    0,  105,    0,  0,   0, 0},
            '{ 0,  15,    0,  -70,    0,   63,  0,   0, 0},
            '{-5,   0,  105,    0, -315,    0, 231,  0, 0},
            '{ 0, -35,    0,  315,    0, -693,  0, 429, 0}
        }
    };

    // Bitwise integer square root, used only to build the tables
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] t;
        int          i;
        r = '0;
        t = v;
        b = 64'h4000_0000_0000_0000;
        for (i = 0; i < 32; i++)
        begin
            if (t >= r + b)
            begin
                t = t - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Fold sqrt(N) / 2^d into the integer coefficients, Q.28, round half up
    function automatic coef_tab_t build_coef(input int sel);
        coef_tab_t tab;
        longint    root;
        longint    prod;
        longint    word;
        int        f;
        int        k;
        tab = '0;
        for (f = 0; f < N_FUNCS; f++)
        begin
            root = longint'(isqrt64(64'(POLY_RAD[sel][f]) << 56));
            for (k = 0; k < N_TERMS; k++)
            begin
                prod = longint'(POLY_C[sel][f][k]) * root;
                word = (prod + (longint'(1) <<< (POLY_SH[sel][f] - 1))) >>> POLY_SH[sel][f];
                tab[f][k] = ACC_W'(word);
            end
        end
        return tab;
    endfunction

    localparam coef_tab_t VALUE_COEF = build_coef(0);
    localparam coef_tab_t SLOPE_COEF = build_coef(1);

    // One Horner step after the product: round, add the coefficient, clamp
    function automatic logic signed [PROD_W-1:0] horner_add(
        input logic signed [PROD_W-1:0] prod,
        input logic signed [ACC_W-1:0]  coef
    );
        logic signed [PROD_W-1:0] rnd;
        logic signed [PROD_W-1:0] sum;
        rnd = (prod + STEP_HALF) >>> FRAC_BITS;
        sum = rnd + PROD_W'(coef);
        if (sum > ACC_MAX)
        begin
            sum = ACC_MAX;
        end
        else if (sum < ACC_MIN)
        begin
            sum = ACC_MIN;
        end
        return sum;
    endfunction

    // Drop to the output scale, round half up, saturate to 24 bits
    function automatic logic signed [OUT_W-1:0] out_round(input logic signed [PROD_W-1:0] acc);
        logic signed [PROD_W-1:0] r;
        r = (acc + OUT_HALF) >>> OUT_SH;
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
        end
        else if (r < OUT_MIN)
        begin
            r = OUT_MIN;
        end
        return OUT_W'(r);
    endfunction

endpackage

@@ sv/hsfe_if.sv @@
// Channel interfaces: request word in, result word out.
interface hsfe_in_if;
    logic                              valid;
    logic                              ready;
    logic [hsfe_pkg::ORDER_W-1:0]      poly_order;
    logic [hsfe_pkg::IDX_W-1:0]        func_index;
    logic [hsfe_pkg::DIR_W-1:0]        direction;
    logic signed [hsfe_pkg::XI_W-1:0]  xi;

    modport source (output valid, poly_order, func_index, direction, xi, input ready);
    modport sink (input valid, poly_order, func_index, direction, xi, output ready);
endinterface

interface hsfe_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hsfe_pkg::OUT_W-1:0]  value;
    logic signed [hsfe_pkg::OUT_W-1:0]  slope;
    logic [hsfe_pkg::STATUS_W-1:0]      status;

    modport source (output valid, value, slope, status, input ready);
    modport sink (input valid, value, slope, status, output ready);
endinterface

@@ sv/hierarchic_shape_function_eval.sv @@
// Top level: pipelined evaluator of the nine 1D hierarchic shape functions and derivatives.
//
//  channel  | dir | word fields                                  | handshake
//  ---------+-----+----------------------------------------------+-------------
//  in_ch    | in  | poly_order[4] func_index[4] direction[2] xi[18]| valid/ready
//  out_ch   | out | value[24] slope[24] status[2]                | valid/ready
//
//  One word per cycle sustained while out_ch.ready stays high.
//  Depth is set by the eight Horner steps, each a multiply stage and an add stage,
//  plus an input check stage and an output rounding register.
//  rst_n clears only the stage valid bits; payload registers hold whatever they had.
//  Each stage loads when it is empty or the stage after it loads, so bubbles collapse
//  and in_ch stays ready while a finished word waits on out_ch, as long as a slot is free.
module hierarchic_shape_function_eval (
    input  logic          clk,
    input  logic          rst_n,
    hsfe_in_if.sink       in_ch,
    hsfe_out_if.source    out_ch
);

    // Stage valid bits, load enables (last enable belongs to the output register)
    logic [hsfe_pkg::N_PIPE-1:0] vld_reg;
    logic [hsfe_pkg::N_PIPE:0]   load;

    hsfe_pkg::pipe_t pipe_reg  [hsfe_pkg::N_PIPE];
    hsfe_pkg::pipe_t pipe_next [hsfe_pkg::N_PIPE];

    logic                              out_vld_reg;
    logic signed [hsfe_pkg::OUT_W-1:0] value_reg;
    logic signed [hsfe_pkg::OUT_W-1:0] value_next;
    logic signed [hsfe_pkg::OUT_W-1:0] slope_reg;
    logic signed [hsfe_pkg::OUT_W-1:0] slope_next;
    hsfe_pkg::status_t                 status_reg;

    // Output register takes a new word when empty or when the current one leaves
    assign load[hsfe_pkg::N_PIPE] = !out_vld_reg || out_ch.ready;

    genvar s;
    generate
        for (s = 0; s < hsfe_pkg::N_PIPE; s++)
        begin : g_load
            assign load[s] = !vld_reg[s] || load[s+1];
        end
    endgenerate

    assign in_ch.ready = load[0];

    // Stage 0: check the request and load the leading coefficient
    always_comb
    begin
        hsfe_pkg::status_t st;
        logic [hsfe_pkg::IDX_W-1:0] idx;
        if (!(in_ch.poly_order inside {[hsfe_pkg::ORDER_MIN:hsfe_pkg::ORDER_MAX]}))
        begin
            st = hsfe_pkg::ST_BAD_ORDER;
        end
        else if (in_ch.func_index > hsfe_pkg::IDX_W'(hsfe_pkg::N_FUNCS - 1))
        begin
            st = hsfe_pkg::ST_BAD_INDEX;
        end
        else if (in_ch.direction != '0)
        begin
            st = hsfe_pkg::ST_BAD_DIR;
        end
        else
        begin
            st = hsfe_pkg::ST_OK;
        end
        // Park bad requests on function zero; the output stage zeroes them anyway
        idx = (st == hsfe_pkg::ST_OK) ? in_ch.func_index : '0;
        pipe_next[0].idx    = idx;
        pipe_next[0].status = st;
        pipe_next[0].x      = in_ch.xi;
        pipe_next[0].val    = hsfe_pkg::PROD_W'(
            signed'(hsfe_pkg::VALUE_COEF[idx][hsfe_pkg::N_TERMS-1]));
        pipe_next[0].slp    = hsfe_pkg::PROD_W'(
            signed'(hsfe_pkg::SLOPE_COEF[idx][hsfe_pkg::N_TERMS-1]));
    end

    // Horner stages: odd stages multiply acc by xi, even stages round and add a_k
    generate
        for (s = 1; s < hsfe_pkg::N_PIPE; s++)
        begin : g_stage
            if (s % 2 == 1)
            begin : g_mul
                logic signed [hsfe_pkg::ACC_W-1:0] acc_v;
                logic signed [hsfe_pkg::ACC_W-1:0] acc_s;
                assign acc_v = pipe_reg[s-1].val[hsfe_pkg::ACC_W-1:0];
                assign acc_s = pipe_reg[s-1].slp[hsfe_pkg::ACC_W-1:0];
                always_comb
                begin
                    pipe_next[s]     = pipe_reg[s-1];
                    pipe_next[s].val = acc_v * signed'(pipe_reg[s-1].x);
                    pipe_next[s].slp = acc_s * signed'(pipe_reg[s-1].x);
                end
            end
            else
            begin : g_add
                // Coefficient index falls from seven at the first add stage to zero at the last
                localparam int K = hsfe_pkg::N_TERMS - 1 - s / 2;
                always_comb
                begin
                    pipe_next[s]     = pipe_reg[s-1];
                    pipe_next[s].val = hsfe_pkg::horner_add(signed'(pipe_reg[s-1].val),
                        signed'(hsfe_pkg::VALUE_COEF[pipe_reg[s-1].idx][K]));
                    pipe_next[s].slp = hsfe_pkg::horner_add(signed'(pipe_reg[s-1].slp),
                        signed'(hsfe_pkg::SLOPE_COEF[pipe_reg[s-1].idx][K]));
                end
            end
        end
    endgenerate

    // Valid bits travel with the data; a stage holds while the next one is blocked
    generate
        for (s = 0; s < hsfe_pkg::N_PIPE; s++)
        begin : g_regs
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (load[s])
                begin
                    vld_reg[s] <= (s == 0) ? in_ch.valid : vld_reg[(s == 0) ? 0 : s - 1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (load[s])
                begin
                    pipe_reg[s] <= pipe_next[s];
                end
            end
        end
    endgenerate

    // Output stage: scale to Q7.16, saturate, zero on any error
    always_comb
    begin
        if (pipe_reg[hsfe_pkg::N_PIPE-1].status == hsfe_pkg::ST_OK)
        begin
            value_next = hsfe_pkg::out_round(signed'(pipe_reg[hsfe_pkg::N_PIPE-1].val));
            slope_next = hsfe_pkg::out_round(signed'(pipe_reg[hsfe_pkg::N_PIPE-1].slp));
        end
        else
        begin
            value_next = '0;
            slope_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (load[hsfe_pkg::N_PIPE])
        begin
            out_vld_reg <= vld_reg[hsfe_pkg::N_PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[hsfe_pkg::N_PIPE])
        begin
            value_reg  <= value_next;
            slope_reg  <= slope_next;
            status_reg <= pipe_reg[hsfe_pkg::N_PIPE-1].status;
        end
    end

    assign out_ch.valid  = out_vld_reg;
    assign out_ch.value  = value_reg;
    assign out_ch.slope  = slope_reg;
    assign out_ch.status = status_reg;

endmodule

@@ tb/sv/shape_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker: predicts every shape-function word and compares it with the block's output.
module shape_result_checker (
    input  logic clk,
    input  logic rst_n,
    hsfe_in_if   in_mon,
    hsfe_out_if  out_mon,
    output int   mismatch_count,
    output int   results_owed
);

    localparam int SHAPES = 9;
    localparam int TERMS  = 9;

    localparam longint ACC_BOUND  = longint'(1) <<< 45;
    localparam longint OUT_TOP    = 64'sd8388607;
    localparam longint OUT_BOTTOM = -64'sd8388608;

    // sqrt(N) / 2^d normalisation per function
    localparam int RADICAND [SHAPES]    = '{1, 1, 6, 10, 14, 2, 22, 26, 30};
    localparam int VALUE_SHIFT [SHAPES] = '{1, 1, 2, 2, 4, 4, 5, 5, 8};
    localparam int SLOPE_SHIFT [SHAPES] = '{1, 1, 1, 2, 2, 4, 4, 5, 5};

    // Integer polynomial coefficients, lowest power first
    localparam int VALUE_POLY [SHAPES][TERMS] = '{
        '{ 1, -1,    0,   0,    0,   0,    0,   0,   0},
        '{ 1,  1,    0,   0,    0,   0,    0,   0,   0},
        '{-1,  0,    1,   0,    0,   0,    0,   0,   0},
        '{ 0, -1,    0,   1,    0,   0,    0,   0,   0},
        '{ 1,  0,   -6,   0,    5,   0,    0,   0,   0},
        '{ 0,  9,    0, -30,    0,  21,    0,   0,   0},
        '{-1,  0,   15,   0,  -35,   0,   21,   0,   0},
        '{ 0, -5,    0,  35,    0, -63,    0,  33,   0},
        '{ 5,  0, -140,   0,  630,   0, -924,   0, 429}
    };

    localparam int SLOPE_POLY [SHAPES][TERMS] = '{
        '{-1,   0,    0,    0,    0,    0,   0,   0, 0},
        '{ 1,   0,    0,    0,    0,    0,   0,   0, 0},
        '{ 0,   1,    0,    0,    0,    0,   0,   0, 0},
        '{-1,   0,    3,    0,    0,    0,   0,   0, 0},
        '{ 0,  -3,    0,    5,    0,    0,   0,   0, 0},
        '{ 9,   0,  -90,    0,  105,    0,   0,   0, 0},
        '{ 0,  15,    0,  -70,    0,   63,   0,   0, 0},
        '{-5,   0,  105,    0, -315,    0, 231,   0, 0},
        '{ 0, -35,    0,  315,    0, -693,   0, 429, 0}
    };

    typedef longint coef_row_t [TERMS];

    typedef struct packed {
        logic signed [hsfe_pkg::OUT_W-1:0] value;
        logic signed [hsfe_pkg::OUT_W-1:0] slope;
        hsfe_pkg::status_t                 status;
    } shape_word_t;

    coef_row_t   value_coef [SHAPES];
    coef_row_t   slope_coef [SHAPES];
    shape_word_t shape_words_due [$];

    // floor((v + 2^(sh-1)) / 2^sh)
    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // floor(sqrt(n * 2^56)), bit by bit from the top
    function automatic longint root_q28(input int n);
        logic [63:0] target;
        logic [63:0] r;
        logic [63:0] trial;
        int          b;
        target = 64'(n) << 56;
        r      = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= target)
            begin
                r = trial;
            end
        end
        return longint'(r);
    endfunction

    function automatic logic signed [hsfe_pkg::OUT_W-1:0] horner_eval(input coef_row_t a,
                                                                      input longint x);
        longint acc;
        int     k;
        acc = a[TERMS-1];
        for (k = TERMS - 2; k >= 0; k--)
        begin
            acc = round_half_up(acc * x, hsfe_pkg::FRAC_BITS) + a[k];
            if (acc > ACC_BOUND)
            begin
                acc = ACC_BOUND;
            end
            else if (acc < -ACC_BOUND)
            begin
                acc = -ACC_BOUND;
            end
        end
        acc = round_half_up(acc, hsfe_pkg::ACC_FRAC - hsfe_pkg::FRAC_BITS);
        if (acc > OUT_TOP)
        begin
            acc = OUT_TOP;
        end
        else if (acc < OUT_BOTTOM)
        begin
            acc = OUT_BOTTOM;
        end
        return hsfe_pkg::OUT_W'(acc);
    endfunction

    // Order is checked first, then index, then direction
    function automatic shape_word_t predict_shape(
        input logic [hsfe_pkg::ORDER_W-1:0]     ord,
        input logic [hsfe_pkg::IDX_W-1:0]       idx,
        input logic [hsfe_pkg::DIR_W-1:0]       dir,
        input logic signed [hsfe_pkg::XI_W-1:0] xi
    );
        shape_word_t w;
        w.value = '0;
        w.slope = '0;
        if (ord < hsfe_pkg::ORDER_MIN || ord > hsfe_pkg::ORDER_MAX)
        begin
            w.status = hsfe_pkg::ST_BAD_ORDER;
        end
        else if (idx >= SHAPES)
        begin
            w.status = hsfe_pkg::ST_BAD_INDEX;
        end
        else if (dir != '0)
        begin
            w.status = hsfe_pkg::ST_BAD_DIR;
        end
        else
        begin
            w.status = hsfe_pkg::ST_OK;
            w.value  = horner_eval(value_coef[idx], longint'(xi));
            w.slope  = horner_eval(slope_coef[idx], longint'(xi));
        end
        return w;
    endfunction

    task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    // Fold the root into the coefficients once
    initial
    begin : coef_fill
        int     f;
        int     k;
        longint root;
        for (f = 0; f < SHAPES; f++)
        begin
            root = root_q28(RADICAND[f]);
            for (k = 0; k < TERMS; k++)
            begin
                value_coef[f][k] = round_half_up(longint'(VALUE_POLY[f][k]) * root, VALUE_SHIFT[f]);
                slope_coef[f][k] = round_half_up(longint'(SLOPE_POLY[f][k]) * root, SLOPE_SHIFT[f]);
            end
        end
    end

    always @(posedge clk)
    begin
        shape_word_t want;
        if (rst_n)
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (shape_words_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, got value %0d slope %0d status %0d",
                             $time, out_mon.value, out_mon.slope, out_mon.status);
                    mismatch_count++;
                end
                else
                begin
                    want = shape_words_due.pop_front();
                    if (out_mon.value !== want.value)
                    begin
                        note_mismatch("value", want.value, out_mon.value);
                    end
                    if (out_mon.slope !== want.slope)
                    begin
                        note_mismatch("slope", want.slope, out_mon.slope);
                    end
                    if (out_mon.status !== want.status)
                    begin
                        note_mismatch("status", want.status, out_mon.status);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                shape_words_due.push_back(predict_shape(in_mon.poly_order, in_mon.func_index,
                                                        in_mon.direction, in_mon.xi));
            end
            results_owed = shape_words_due.size();
        end
    end

endmodule

@@ tb/sv/hierarchic_shape_function_eval_test.sv @@
`timescale 1ns / 1ps
// Testbench top: drives request words into the shape evaluator, throttles results, gives the verdict.
module hierarchic_shape_function_eval_test;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int RESET_CYCLES    = 10;
    localparam int IDLE_PCT        = 23;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES     = 40;

    // Shape of the random part
    localparam int OPEN_WORDS  = 350;
    localparam int CALM_WORDS  = 150;
    localparam int BURST_WORDS = 100;
    localparam int LAST_WORDS  = 400;

    // Ends of the xi range
    localparam logic signed [hsfe_pkg::XI_W-1:0] XI_LOW  = hsfe_pkg::XI_W'(-131072);
    localparam logic signed [hsfe_pkg::XI_W-1:0] XI_HIGH = hsfe_pkg::XI_W'(131071);

    logic        clk;
    logic        rst_n;
    int          mismatch_count;
    int          results_owed;
    int unsigned cycle_count = 0;

    // Flags shared by the sender and receiver processes
    bit sender_calm;
    bit receiver_calm;
    bit hold_request;

    hsfe_in_if  in_ch ();
    hsfe_out_if out_ch ();

    hierarchic_shape_function_eval u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    shape_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Watchdog: count every cycle and give up at the limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one word at the falling edge, hold it until accepted, return at the next falling edge.
    // Random idle cycles go ahead of the word unless the sender is in a calm stretch.
    task automatic offer_word(
        input logic [hsfe_pkg::ORDER_W-1:0]     ord,
        input logic [hsfe_pkg::IDX_W-1:0]       idx,
        input logic [hsfe_pkg::DIR_W-1:0]       dir,
        input logic signed [hsfe_pkg::XI_W-1:0] xi
    );
        while (!sender_calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.poly_order <= ord;
        in_ch.func_index <= idx;
        in_ch.direction  <= dir;
        in_ch.xi         <= xi;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Mostly well-formed requests, half of them inside the reference interval;
    // the rest is noise over every field so each bit takes both values
    task automatic offer_random_word();
        logic [hsfe_pkg::ORDER_W-1:0]     ord;
        logic [hsfe_pkg::IDX_W-1:0]       idx;
        logic [hsfe_pkg::DIR_W-1:0]       dir;
        logic signed [hsfe_pkg::XI_W-1:0] xi;
        if ($urandom_range(99) < 75)
        begin
            ord = hsfe_pkg::ORDER_W'($urandom_range(hsfe_pkg::ORDER_MAX, hsfe_pkg::ORDER_MIN));
            idx = hsfe_pkg::IDX_W'($urandom_range(8, 0));
            dir = '0;
            if ($urandom_range(1) == 1)
            begin
                xi = hsfe_pkg::XI_W'(int'($urandom_range(131072, 0)) - 65536);
            end
            else
            begin
                xi = hsfe_pkg::XI_W'($urandom);
            end
        end
        else
        begin
            ord = hsfe_pkg::ORDER_W'($urandom);
            idx = hsfe_pkg::IDX_W'($urandom);
            dir = hsfe_pkg::DIR_W'($urandom);
            xi  = hsfe_pkg::XI_W'($urandom);
        end
        offer_word(ord, idx, dir, xi);
    endtask

    // Hold valid low at the current falling edge and wait until every result is back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (results_owed != 0);
    endtask

    // Receiver: stall at random, never in a calm stretch, and once for a long hold-off
    initial
    begin : receiver
        int unsigned hold_left;
        bit          hold_taken;
        hold_left    = 0;
        hold_taken   = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ch.ready <= receiver_calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.poly_order = '0;
        in_ch.func_index = '0;
        in_ch.direction  = '0;
        in_ch.xi         = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every function at both ends of the xi range; the far ends saturate
        // the high-degree terms. Sweep all valid orders along the way.
        for (i = 0; i < 9; i++)
        begin
            offer_word(hsfe_pkg::ORDER_W'(hsfe_pkg::ORDER_MIN + i % 7), hsfe_pkg::IDX_W'(i),
                       2'd0, XI_LOW);
        end
        for (i = 0; i < 9; i++)
        begin
            offer_word(hsfe_pkg::ORDER_W'(hsfe_pkg::ORDER_MAX), hsfe_pkg::IDX_W'(i),
                       2'd0, XI_HIGH);
        end
        offer_word(4'd3, 4'd8, 2'd0, 18'sd0);

        // Bad order, including one that is also a bad index and bad direction
        offer_word(4'd0, 4'd4, 2'd0, 18'sd65536);
        offer_word(4'd8, 4'd2, 2'd0, -18'sd65536);
        offer_word(4'd15, 4'd15, 2'd3, XI_HIGH);

        // Bad index, one with a bad direction too, then bad direction alone
        offer_word(4'd7, 4'd9, 2'd0, 18'sd1000);
        offer_word(4'd1, 4'd15, 2'd3, -18'sd1);
        offer_word(4'd2, 4'd5, 2'd1, 18'sd32768);
        offer_word(4'd6, 4'd0, 2'd2, -18'sd32768);

        // Random words with idling on both sides
        for (i = 0; i < OPEN_WORDS; i++)
        begin
            offer_random_word();
        end

        // Long stretch with no idling at all
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        for (i = 0; i < CALM_WORDS; i++)
        begin
            offer_random_word();
        end
        receiver_calm = 1'b0;

        // Back-pressure: receiver holds off while words keep coming, so the pipe fills
        hold_request = 1'b1;
        for (i = 0; i < BURST_WORDS; i++)
        begin
            offer_random_word();
        end
        sender_calm = 1'b0;

        // Pause until the pipe is empty, then go on
        drain_results();
        for (i = 0; i < LAST_WORDS; i++)
        begin
            offer_random_word();
        end

        // Wait for the last results, then give stray words time to show
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
